@@ design/getsp_pkg.sv @@
// getsp_pkg: shared constants and types for the graph shortest path unit
// no dependencies
`default_nettype none
package getsp_pkg;
  localparam int NUM_VERTICES_DEF = 32;
  localparam int MAX_DEGREE_DEF   = 32;
  localparam int RESULT_LIMIT     = 32;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;
  localparam logic [1:0] REQ_NONE   = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [1:0]        status;
    logic [4:0]        vertex_id;
    logic signed [5:0] distance;
    logic signed [5:0] predecessor;
    logic              last;
  } result_t;
endpackage
`default_nettype wire

@@ design/getsp_nbr_mem.sv @@
// getsp_nbr_mem: neighbor list storage, one write port, one registered read port
// depends on nothing
`default_nettype none
module getsp_nbr_mem #(
  parameter int AW = 10
) (
  input  wire           clk,
  input  wire           we,
  input  wire  [AW-1:0] waddr,
  input  wire  [4:0]    wdata,
  input  wire  [AW-1:0] raddr,
  output logic [4:0]    rdata
);
  logic [4:0] mem [0:(1<<AW)-1];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ design/graph_edge_table_shortest_path.sv @@
// Graph neighbor-list unit with unit-weight shortest path queries. One
// request is handled at a time; a new request is taken only in idle with no
// result waiting. An insert writes the origin list, and an undirected one
// also the other list, before it answers; invalid or full requests answer
// after decode. A remove scans the origin list entry by entry (registered
// memory read, then compare) and then moves the last entry into the hole,
// per direction; a miss answers after the whole list is scanned. A query
// clears its vertex tables, then each selection step scans the vertices in
// use and relaxes the chosen vertex's list entry by entry (read, then
// compare), and at the end it gives one result per vertex per cycle while
// the output side accepts.
// depends on getsp_pkg, getsp_nbr_mem
`default_nettype none
module graph_edge_table_shortest_path
  import getsp_pkg::*;
#(
  parameter int NUM_VERTICES = NUM_VERTICES_DEF,
  parameter int MAX_DEGREE   = MAX_DEGREE_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_we,
  input  wire  [5:0]  cfg_wdata,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [15:0] in_tdata,   // req_type, vertex_a, vertex_b, one_way
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [23:0] out_tdata,  // status, vertex_id, distance, predecessor
  output logic        out_tlast
);
  localparam int VW = $clog2(NUM_VERTICES);
  localparam int DW = $clog2(MAX_DEGREE + 1);
  localparam int KW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int AW = VW + KW;
  localparam int NL = (NUM_VERTICES < RESULT_LIMIT) ? NUM_VERTICES : RESULT_LIMIT;

  localparam logic [3:0] S_IDLE = 4'd0, S_DEC = 4'd1, S_INS1 = 4'd2, S_INS2 = 4'd3,
    S_SCAN = 4'd4, S_SCANW = 4'd5, S_MOVE = 4'd6, S_MOVW = 4'd7, S_CLR = 4'd8,
    S_SEL = 4'd9, S_RELAX = 4'd10, S_RELW = 4'd11, S_EMIT = 4'd12, S_RESP = 4'd13;

  logic [3:0] state_r;
  logic [5:0] vcnt_r;
  logic [1:0] req_r;
  logic [5:0] a_r, b_r;
  logic       ow_r, rev_r;
  logic [6:0] n_r;
  logic [DW-1:0] deg_r [NUM_VERTICES];
  logic signed [5:0] dist_r [NUM_VERTICES];
  logic signed [5:0] pred_r [NUM_VERTICES];
  logic       vis_r [NUM_VERTICES];
  logic [6:0] v_r;
  logic [DW:0] k_r;
  logic [6:0] pick_r;
  logic [VW-1:0] from_r;
  logic [5:0] to_r;
  logic [KW-1:0] hit_r;
  logic [1:0] st_r;
  result_t res_r;
  logic    ovalid_r;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [4:0]    wdata, rdata;

  getsp_nbr_mem #(.AW(AW)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  wire [6:0] n_eff = (vcnt_r == 6'd0) ? 7'd1 :
                     ({1'b0, vcnt_r} > 7'(NL)) ? 7'(NL) : {1'b0, vcnt_r};
  wire busy_out = ovalid_r && !out_tready;
  wire emit_fire = ((state_r == S_EMIT) || (state_r == S_RESP)) && !busy_out;

  assign in_tready  = (state_r == S_IDLE) && !busy_out;
  assign out_tvalid = ovalid_r;
  assign out_tdata  = {5'd0, res_r.predecessor, res_r.distance, res_r.vertex_id,
                       res_r.status};
  assign out_tlast  = res_r.last;

  logic [VW-1:0] av, bv, pv, wv;
  logic [DW-1:0] da, db, dfrom, dlast;
  logic signed [5:0] nd;
  assign av = a_r[VW-1:0];
  assign bv = b_r[VW-1:0];
  assign pv = pick_r[VW-1:0];
  assign wv = VW'(rdata);
  assign da = deg_r[av];
  assign db = deg_r[bv];
  assign dfrom = deg_r[from_r];
  assign dlast = dfrom - DW'(1);
  assign nd = (dist_r[pv] == 6'sd31) ? 6'sd31 : dist_r[pv] + 6'sd1;

  always_comb begin
    we = 1'b0; waddr = '0; wdata = '0;
    raddr = {from_r, k_r[KW-1:0]};
    if (state_r == S_INS1) begin
      we = 1'b1; waddr = {av, da[KW-1:0]}; wdata = b_r[4:0];
    end
    if (state_r == S_INS2) begin
      we = 1'b1; waddr = {bv, db[KW-1:0]}; wdata = a_r[4:0];
    end
    if (state_r == S_MOVE) raddr = {from_r, dlast[KW-1:0]};
    if (state_r == S_MOVW) begin
      we = 1'b1; waddr = {from_r, hit_r}; wdata = rdata;
    end
    if (state_r == S_RELAX) raddr = {pv, k_r[KW-1:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ovalid_r <= 1'b0;
    else if (emit_fire) ovalid_r <= 1'b1;
    else if (out_tready) ovalid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      vcnt_r <= 6'd32;
      for (int i = 0; i < NUM_VERTICES; i++) begin
        deg_r[i] <= '0; dist_r[i] <= -6'sd1; pred_r[i] <= -6'sd1; vis_r[i] <= 1'b0;
      end
    end else begin
      if (cfg_we) vcnt_r <= cfg_wdata;
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            req_r <= in_tdata[1:0]; a_r <= in_tdata[7:2]; b_r <= in_tdata[13:8];
            ow_r <= in_tdata[14]; n_r <= n_eff;
            if (in_tdata[1:0] != REQ_NONE) state_r <= S_DEC;
          end
        end
        S_DEC: begin
          if ({1'b0, a_r} >= n_r || (req_r != REQ_QUERY && {1'b0, b_r} >= n_r)) begin
            st_r <= ST_INVALID; state_r <= S_RESP;
          end else if (req_r == REQ_INSERT) begin
            if ((ow_r && da >= DW'(MAX_DEGREE)) ||
                (!ow_r && a_r == b_r &&
                 ({1'b0, da} + (DW+1)'(2)) > (DW+1)'(MAX_DEGREE)) ||
                (!ow_r && a_r != b_r && (da >= DW'(MAX_DEGREE) ||
                                         db >= DW'(MAX_DEGREE)))) begin
              st_r <= ST_FULL; state_r <= S_RESP;
            end else begin
              st_r <= ST_OK; state_r <= S_INS1;
            end
          end else if (req_r == REQ_REMOVE) begin
            st_r <= ST_OK;
            from_r <= av; to_r <= b_r; rev_r <= 1'b0; k_r <= '0; state_r <= S_SCAN;
          end else begin
            st_r <= ST_OK; v_r <= '0; state_r <= S_CLR;
          end
        end
        S_INS1: begin
          deg_r[av] <= da + DW'(1);
          state_r <= ow_r ? S_RESP : S_INS2;
        end
        S_INS2: begin
          deg_r[bv] <= db + DW'(1);
          state_r <= S_RESP;
        end
        S_SCAN: begin
          if (k_r >= (DW+1)'(dfrom)) begin
            if (!rev_r) st_r <= ST_NOTFOUND;
            state_r <= S_RESP;
          end else state_r <= S_SCANW;
        end
        S_SCANW: begin
          if ({1'b0, rdata} == to_r) begin
            hit_r <= k_r[KW-1:0]; state_r <= S_MOVE;
          end else begin
            k_r <= k_r + 1'b1; state_r <= S_SCAN;
          end
        end
        S_MOVE: state_r <= S_MOVW;
        S_MOVW: begin
          deg_r[from_r] <= dlast;
          if (!rev_r && !ow_r) begin
            from_r <= bv; to_r <= a_r; rev_r <= 1'b1; k_r <= '0; state_r <= S_SCAN;
          end else state_r <= S_RESP;
        end
        S_CLR: begin
          dist_r[v_r[VW-1:0]] <= (v_r[VW-1:0] == av) ? 6'sd0 : -6'sd1;
          pred_r[v_r[VW-1:0]] <= -6'sd1;
          vis_r[v_r[VW-1:0]]  <= 1'b0;
          if (v_r == 7'(NUM_VERTICES - 1)) begin
            v_r <= '0; pick_r <= 7'h7f; state_r <= S_SEL;
          end else v_r <= v_r + 1'b1;
        end
        S_SEL: begin
          if (v_r < n_r && dist_r[v_r[VW-1:0]] >= 0 && !vis_r[v_r[VW-1:0]] &&
              (pick_r[6] || dist_r[pv] > dist_r[v_r[VW-1:0]]))
            pick_r <= v_r;
          if (v_r + 1'b1 >= n_r || v_r == 7'(NUM_VERTICES - 1)) begin
            if (pick_r[6] && !(v_r < n_r && dist_r[v_r[VW-1:0]] >= 0 &&
                               !vis_r[v_r[VW-1:0]])) begin
              v_r <= '0; state_r <= S_EMIT;
            end else state_r <= S_RELAX;
            k_r <= '0;
          end else v_r <= v_r + 1'b1;
        end
        S_RELAX: begin
          vis_r[pv] <= 1'b1;
          if (k_r >= (DW+1)'(deg_r[pv])) begin
            v_r <= '0; pick_r <= 7'h7f; state_r <= S_SEL;
          end else state_r <= S_RELW;
        end
        S_RELW: begin
          if ({2'b0, rdata} < n_r && (dist_r[wv] < 6'sd0 || dist_r[wv] > nd)) begin
            dist_r[wv] <= nd;
            pred_r[wv] <= 6'(pick_r);
          end
          k_r <= k_r + 1'b1; state_r <= S_RELAX;
        end
        S_EMIT: begin
          if (!busy_out) begin
            res_r <= '{status: ST_OK, vertex_id: v_r[4:0],
                       distance: dist_r[v_r[VW-1:0]],
                       predecessor: pred_r[v_r[VW-1:0]],
                       last: (v_r + 1'b1 == n_r)};
            if (v_r + 1'b1 == n_r) state_r <= S_IDLE;
            else v_r <= v_r + 1'b1;
          end
        end
        S_RESP: begin
          if (!busy_out) begin
            res_r <= '{status: st_r, vertex_id: 5'd0, distance: 6'sd0,
                       predecessor: 6'sd0, last: 1'b1};
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ verif/testbench.sv @@
// testbench for graph_edge_table_shortest_path: drives edit and query requests,
// predicts every result with a scoreboard class and checks them in order
// depends on getsp_pkg and the design files
`timescale 1ns / 1ps
module testbench;
  import getsp_pkg::*;

  localparam int NV = 32;
  localparam int MD = 32;
  localparam int CYCLE_LIMIT = 5000000;

  class path_scoreboard;
    logic [5:0] vcount;
    logic [4:0] nbr [NV][MD];
    int degree [NV];
    result_t expected_q [$];
    int queries;

    function void clear();
      vcount = 6'd32;
      queries = 0;
      expected_q.delete();
      foreach (degree[v]) degree[v] = 0;
    endfunction

    function int active_n();
      if (vcount == 0) return 1;
      if (vcount > NV) return NV;
      return vcount;
    endfunction

    function void push(logic [1:0] st, int id, int hop, int pred, bit last);
      result_t r;
      r.status = st;
      r.vertex_id = id[4:0];
      r.distance = hop[5:0];
      r.predecessor = pred[5:0];
      r.last = last;
      expected_q.push_back(r);
    endfunction

    function bit drop(int from, int to);
      int i;
      i = 0;
      while (i < degree[from] && nbr[from][i] != to) i++;
      if (i == degree[from]) return 0;
      degree[from]--;
      nbr[from][i] = nbr[from][degree[from]];
      return 1;
    endfunction

    function void append(int from, int to);
      nbr[from][degree[from]] = to[4:0];
      degree[from]++;
    endfunction

    function void shortest_paths(int start, int n);
      int hop [NV];
      int pred [NV];
      bit seen [NV];
      int pick, w, d;
      foreach (hop[v]) begin
        hop[v] = -1;
        pred[v] = -1;
        seen[v] = 0;
      end
      hop[start] = 0;
      forever begin
        pick = -1;
        for (int v = 0; v < n; v++)
          if (hop[v] >= 0 && !seen[v] && (pick < 0 || hop[pick] > hop[v])) pick = v;
        if (pick < 0) break;
        seen[pick] = 1;
        for (int k = 0; k < degree[pick]; k++) begin
          w = int'(nbr[pick][k]);
          if (w < n && (hop[w] < 0 || hop[w] > hop[pick] + 1)) begin
            hop[w] = hop[pick] + 1;
            pred[w] = pick;
          end
        end
      end
      for (int v = 0; v < n; v++) begin
        d = hop[v] > 31 ? 31 : hop[v];
        push(ST_OK, v, d, pred[v], v == n - 1);
      end
    endfunction

    function void note_request(logic [1:0] req, int a, int b, bit one_way);
      int n;
      bit room;
      n = active_n();
      if (req == REQ_NONE) return;
      if (req == REQ_QUERY) begin
        queries++;
        if (a >= n) push(ST_INVALID, 0, 0, 0, 1);
        else shortest_paths(a, n);
        return;
      end
      if (a >= n || b >= n) begin
        push(ST_INVALID, 0, 0, 0, 1);
        return;
      end
      if (req == REQ_INSERT) begin
        if (one_way) room = degree[a] < MD;
        else if (a == b) room = degree[a] + 2 <= MD;
        else room = degree[a] < MD && degree[b] < MD;
        if (!room) begin
          push(ST_FULL, 0, 0, 0, 1);
          return;
        end
        append(a, b);
        if (!one_way) append(b, a);
        push(ST_OK, 0, 0, 0, 1);
        return;
      end
      if (!drop(a, b)) begin
        push(ST_NOTFOUND, 0, 0, 0, 1);
        return;
      end
      if (!one_way) void'(drop(b, a));
      push(ST_OK, 0, 0, 0, 1);
    endfunction

    // returns a mismatch description, empty when the transaction matches
    function string check_result(logic [23:0] data, logic last);
      result_t e;
      string msg;
      if (expected_q.size() == 0)
        return $sformatf("unexpected result data=%h last=%b", data, last);
      e = expected_q.pop_front();
      msg = "";
      if (data[1:0] !== e.status)
        msg = {msg, $sformatf(" status %0d/%0d", data[1:0], e.status)};
      if (data[6:2] !== e.vertex_id)
        msg = {msg, $sformatf(" vertex_id %0d/%0d", data[6:2], e.vertex_id)};
      if (data[12:7] !== e.distance)
        msg = {msg, $sformatf(" distance %0d/%0d", $signed(data[12:7]), e.distance)};
      if (data[18:13] !== e.predecessor)
        msg = {msg, $sformatf(" predecessor %0d/%0d", $signed(data[18:13]), e.predecessor)};
      if (data[23:19] !== 5'd0)
        msg = {msg, $sformatf(" padding %h", data[23:19])};
      if (last !== e.last) msg = {msg, $sformatf(" last %b/%b", last, e.last)};
      if (msg != "") msg = {"mismatch (got/expected):", msg};
      return msg;
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [5:0] cfg_wdata;
  logic in_tvalid;
  logic in_tready;
  logic [15:0] in_tdata;    // req_type, vertex_a, vertex_b, one_way
  logic out_tvalid;
  logic out_tready;
  logic [23:0] out_tdata;   // status, vertex_id, distance, predecessor
  logic out_tlast;

  path_scoreboard sb;
  int errors;
  int cycles;
  int items_sent;
  int results_seen;
  bit no_idle;
  int stall_left;

  graph_edge_table_shortest_path i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  task automatic report(string msg);
    $display("ERROR at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d results still expected", sb.expected_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side: check each transaction and draw random stalls
  always @(posedge clk) begin
    string msg;
    logic next_ready;
    next_ready = out_tready;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      msg = sb.check_result(out_tdata, out_tlast);
      if (msg != "") report(msg);
      stall_left = no_idle ? 0 : $urandom_range(0, 4);
    end
    if (stall_left > 0) begin
      next_ready = 1'b0;
      stall_left--;
    end else begin
      next_ready = 1'b1;
    end
    out_tready <= next_ready;
  end

  task automatic send(logic [1:0] req, int a, int b, bit one_way);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, one_way, b[5:0], a[5:0], req};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(req, a, b, one_way);
    items_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() > 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  task automatic set_count(logic [5:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.vcount = value;
  endtask

  task automatic random_item();
    int n, r, a, b;
    n = sb.active_n();
    r = $urandom_range(0, 99);
    a = $urandom_range(0, n - 1);
    b = $urandom_range(0, n - 1);
    if (r < 50) begin
      send(REQ_INSERT, a, b, 1'($urandom_range(0, 1)));
    end else if (r < 70) begin
      if (sb.degree[a] > 0 && $urandom_range(0, 3) != 0)
        b = int'(sb.nbr[a][$urandom_range(0, sb.degree[a] - 1)]);
      send(REQ_REMOVE, a, b, 1'($urandom_range(0, 1)));
    end else if (r < 85) begin
      send(REQ_QUERY, a, $urandom_range(0, 63), 1'($urandom_range(0, 1)));
    end else if (r < 93) begin
      send(2'($urandom_range(0, 2)), $urandom_range(0, 63), $urandom_range(0, 63),
           1'($urandom_range(0, 1)));
    end else begin
      send(REQ_NONE, $urandom_range(0, 63), $urandom_range(0, 63),
           1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    logic [5:0] counts [9];
    sb = new();
    sb.clear();
    items_sent = 0;
    no_idle = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 6'd0;
    in_tvalid = 1'b0;
    in_tdata = 16'd0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed edits and queries at full size and at vertex counts 10, 0 and 63
    send(REQ_INSERT, 0, 1, 0);
    send(REQ_INSERT, 1, 2, 1);
    send(REQ_INSERT, 31, 30, 0);
    send(REQ_QUERY, 0, 0, 0);
    send(REQ_QUERY, 31, 63, 1);
    send(REQ_REMOVE, 1, 2, 1);
    send(REQ_REMOVE, 1, 2, 1);
    send(REQ_REMOVE, 0, 1, 0);
    send(REQ_INSERT, 63, 0, 0);
    send(REQ_INSERT, 0, 40, 1);
    send(REQ_QUERY, 63, 0, 0);
    send(REQ_NONE, 5, 5, 1);
    send(REQ_INSERT, 5, 5, 0);
    send(REQ_QUERY, 5, 0, 0);
    send(REQ_INSERT, 2, 9, 0);
    send(REQ_INSERT, 9, 20, 0);
    set_count(6'd10);
    send(REQ_QUERY, 2, 0, 0);
    send(REQ_INSERT, 9, 10, 0);
    set_count(6'd0);
    send(REQ_QUERY, 0, 0, 0);
    send(REQ_INSERT, 0, 1, 0);
    set_count(6'd63);
    send(REQ_QUERY, 9, 0, 0);

    // full list, undirected self-loop needing two free slots
    for (int i = 0; i < 31; i++) send(REQ_INSERT, 3, $urandom_range(0, 31), 1);
    send(REQ_INSERT, 3, 3, 0);
    send(REQ_INSERT, 3, 3, 1);
    send(REQ_INSERT, 3, 7, 1);
    send(REQ_INSERT, 7, 3, 0);
    send(REQ_QUERY, 3, 0, 0);

    counts = '{6'd32, 6'd8, 6'd3, 6'd63, 6'd17, 6'd1, 6'd32, 6'd0, 6'd5};
    foreach (counts[p]) begin
      set_count(p == 8 ? 6'($urandom_range(2, 31)) : counts[p]);
      no_idle = (p % 4 == 2);
      repeat (26) random_item();
    end
    no_idle = 0;

    drain();
    repeat (2200) @(posedge clk);
    $display("covered %0d requests (%0d queries) and %0d results over several vertex counts",
             items_sent, sb.queries, results_seen);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
